>>> rtl/mcpp_pkg.sv
// ----------------------------------------------------------------------------
// Path payoff engine package
// Shared widths, configuration register indexes and a saturating add helper.
// ----------------------------------------------------------------------------
package mcpp_pkg;

    // Field and datapath widths
    localparam int PRICE_W    = 32;
    localparam int TOTAL_W    = 48;
    localparam int COUNT_W    = 24;
    localparam int STEP_W     = 16;
    localparam int SAMPLE_W   = 16;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Shared multiplier: one 16-bit chunk times a 32-bit operand
    localparam int CHUNK_W    = 16;
    localparam int PROD_W     = CHUNK_W + PRICE_W;
    localparam int OPA_W      = 48;
    localparam int CHUNKS     = OPA_W / CHUNK_W;
    localparam int ACC_W      = OPA_W + PRICE_W;
    localparam int CNT_W      = 2;

    // Growth factor plus vol term, Q.42 signed with headroom
    localparam int F_W        = 50;
    localparam int F_FRAC     = 12;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPOT    = 3'd0,
        CFG_STRIKE  = 3'd1,
        CFG_GROWTH  = 3'd2,
        CFG_VOL     = 3'd3,
        CFG_STEPS   = 3'd4,
        CFG_AVG     = 3'd5,
        CFG_MEAN    = 3'd6,
        CFG_MODE    = 3'd7
    } cfg_index_t;

    // Register reset values
    localparam logic [PRICE_W-1:0] GROWTH_RESET = 32'h4000_0000;
    localparam logic [PRICE_W-1:0] SCALE_RESET  = 32'h8000_0000;
    localparam logic [STEP_W-1:0]  STEPS_RESET  = 16'd1;

    // Pricing mode bits
    localparam int MODE_PUT_BIT = 0;
    localparam int MODE_AVG_BIT = 1;

    // Saturating 48-bit add
    function automatic logic [TOTAL_W-1:0] add_sat48(
        input logic [TOTAL_W-1:0] a,
        input logic [TOTAL_W-1:0] b
    );
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

endpackage

>>> rtl/monte_carlo_path_payoff.sv
// ----------------------------------------------------------------------------
// Monte Carlo path payoff engine
// Euler steps of a fixed-point price path, path close with call or put
// payoff, running payoff total and scaled price estimate.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per time step: a
//   normal sample and a clear flag. in_stall is high while a word is being
//   worked on; one 16x32 multiplier is shared by every product, taking one
//   16-bit chunk of a 48-bit operand per cycle.
//   A word that keeps the path open runs the price product; a path that
//   closes on the terminal price adds the estimate product, and one that
//   closes on the path average adds the average product too. A factor that
//   clamps the price to zero skips the price product. Each product is 48x32.
//   Output channel (out_valid / out_stall) carries one word per closed path:
//   payoff, total, path count and estimate, held in an output register. A
//   new input word is taken while a result waits; if a second result is
//   ready before the first is taken, the engine holds it until the output
//   register frees.
//   Configuration is written through cfg_we / cfg_index / cfg_data while
//   the engine is idle; each write lands at the clock edge.
//   Reset (rst_n low, asynchronous) restores register defaults and clears
//   path, total and count state.
// ----------------------------------------------------------------------------
module monte_carlo_path_payoff
    import mcpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Sample channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic signed [SAMPLE_W-1:0] normal_sample,
    input  logic                  clear_totals,
    // Result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [PRICE_W-1:0]    path_payoff,
    output logic [TOTAL_W-1:0]    payoff_total,
    output logic [COUNT_W-1:0]    paths_done,
    output logic [PRICE_W-1:0]    price_estimate
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_MUL,
        S_NEWP,
        S_PCLOSE,
        S_PAY,
        S_EST
    } state_t;

    typedef enum logic [1:0] {
        PH_PRICE,
        PH_AVG,
        PH_EST
    } phase_t;

    // Control and datapath registers
    state_t               state_reg,   state_next;
    phase_t               phase_reg,   phase_next;
    logic [CNT_W-1:0]     cnt_reg,     cnt_next;
    logic [ACC_W-1:0]     acc_reg,     acc_next;
    logic [OPA_W-1:0]     opa_reg,     opa_next;
    logic [PRICE_W-1:0]   opb_reg,     opb_next;
    logic                 neg_reg,     neg_next;
    logic [PRICE_W-1:0]   pclose_reg,  pclose_next;

    // Configuration registers
    logic [PRICE_W-1:0]   spot_reg,    spot_next;
    logic [PRICE_W-1:0]   strike_reg,  strike_next;
    logic [PRICE_W-1:0]   growth_reg,  growth_next;
    logic [PRICE_W-1:0]   vol_reg,     vol_next;
    logic [STEP_W-1:0]    steps_reg,   steps_next;
    logic [PRICE_W-1:0]   avg_scale_reg,  avg_scale_next;
    logic [PRICE_W-1:0]   mean_scale_reg, mean_scale_next;
    logic [MODE_W-1:0]    mode_reg,    mode_next;

    // Path and total state
    logic [PRICE_W-1:0]   cur_price_reg, cur_price_next;
    logic [TOTAL_W-1:0]   avg_sum_reg,   avg_sum_next;
    logic [STEP_W-1:0]    step_idx_reg,  step_idx_next;
    logic [TOTAL_W-1:0]   total_reg,     total_next;
    logic [COUNT_W-1:0]   count_reg,     count_next;

    // Output register
    logic                 out_valid_reg,   out_valid_next;
    logic [PRICE_W-1:0]   payoff_reg,      payoff_next;
    logic [PRICE_W-1:0]   out_payoff_reg,  out_payoff_next;
    logic [TOTAL_W-1:0]   out_total_reg,   out_total_next;
    logic [COUNT_W-1:0]   out_count_reg,   out_count_next;
    logic [PRICE_W-1:0]   out_est_reg,     out_est_next;

    // Shared multiplier
    logic [CHUNK_W-1:0]   mul_a;
    logic [PRICE_W-1:0]   mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [CHUNK_W-1:0]   sample_mag;
    logic [CHUNK_W-1:0]   opa_chunk;

    // Step arithmetic
    logic [F_W-1:0]       grow_ext;
    logic [F_W-1:0]       vol_term;
    logic [F_W-1:0]       f_val;
    logic                 f_clamp;
    logic [PRICE_W-1:0]   price_sel;
    logic [PRICE_W-1:0]   newp;
    logic [PRICE_W-1:0]   scaled31;
    logic [TOTAL_W-1:0]   avg_upd;
    logic                 path_close;
    logic [PRICE_W-1:0]   payoff_val;
    logic [TOTAL_W-1:0]   total_upd;
    logic                 in_accept;
    logic                 out_free;

    assign in_accept = in_valid && (state_reg == S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;

    // Pick the operand chunk, high chunk first
    always_comb
    begin
        case (cnt_reg)
            2'd0:    opa_chunk = opa_reg[OPA_W-1 -: CHUNK_W];
            2'd1:    opa_chunk = opa_reg[OPA_W-CHUNK_W-1 -: CHUNK_W];
            default: opa_chunk = opa_reg[CHUNK_W-1:0];
        endcase
    end

    // Magnitude of the sample; the most negative code maps to 2^15
    assign sample_mag = normal_sample[SAMPLE_W-1] ? CHUNK_W'(-normal_sample)
                                                  : CHUNK_W'(normal_sample);

    assign mul_a = (state_reg == S_IDLE) ? sample_mag : opa_chunk;
    assign mul_b = (state_reg == S_IDLE) ? vol_reg : opb_reg;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Growth factor plus signed vol term
    assign grow_ext = {{(F_W-PRICE_W-F_FRAC){1'b0}}, growth_reg, {F_FRAC{1'b0}}};
    assign vol_term = {{(F_W-PROD_W){1'b0}}, acc_reg[PROD_W-1:0]};
    assign f_val    = neg_reg ? (grow_ext - vol_term) : (grow_ext + vol_term);
    assign f_clamp  = f_val[F_W-1] || (f_val[F_W-2:F_FRAC] == '0);

    assign price_sel = (step_idx_reg == '0) ? spot_reg : cur_price_reg;

    // Take the product down by 2^30 or 2^31, saturating to 32 bits
    assign newp     = (|acc_reg[ACC_W-1:PRICE_W+30]) ? {PRICE_W{1'b1}}
                                                     : acc_reg[PRICE_W+29:30];
    assign scaled31 = (|acc_reg[ACC_W-1:PRICE_W+31]) ? {PRICE_W{1'b1}}
                                                     : acc_reg[PRICE_W+30:31];

    assign avg_upd    = add_sat48(avg_sum_reg, TOTAL_W'(newp));
    assign path_close = ({1'b0, step_idx_reg} + 17'd1) >= {1'b0, steps_reg};

    // Call or put payoff against the strike
    always_comb
    begin
        if (mode_reg[MODE_PUT_BIT])
        begin
            payoff_val = (strike_reg > pclose_reg) ? (strike_reg - pclose_reg) : '0;
        end
        else
        begin
            payoff_val = (pclose_reg > strike_reg) ? (pclose_reg - strike_reg) : '0;
        end
    end

    assign total_upd = add_sat48(total_reg, TOTAL_W'(payoff_val));

    // Next-state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        opa_next        = opa_reg;
        opb_next        = opb_reg;
        neg_next        = neg_reg;
        pclose_next     = pclose_reg;
        spot_next       = spot_reg;
        strike_next     = strike_reg;
        growth_next     = growth_reg;
        vol_next        = vol_reg;
        steps_next      = steps_reg;
        avg_scale_next  = avg_scale_reg;
        mean_scale_next = mean_scale_reg;
        mode_next       = mode_reg;
        cur_price_next  = cur_price_reg;
        avg_sum_next    = avg_sum_reg;
        step_idx_next   = step_idx_reg;
        total_next      = total_reg;
        count_next      = count_reg;
        payoff_next     = payoff_reg;
        out_payoff_next = out_payoff_reg;
        out_total_next  = out_total_reg;
        out_count_next  = out_count_reg;
        out_est_next    = out_est_reg;

        // Drop the output word once taken
        out_valid_next = out_valid_reg && out_stall;

        // Configuration writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPOT:   spot_next       = cfg_data;
                CFG_STRIKE: strike_next     = cfg_data;
                CFG_GROWTH: growth_next     = cfg_data;
                CFG_VOL:    vol_next        = cfg_data;
                CFG_STEPS:  steps_next      = cfg_data[STEP_W-1:0];
                CFG_AVG:    avg_scale_next  = cfg_data;
                CFG_MEAN:   mean_scale_next = cfg_data;
                CFG_MODE:   mode_next       = cfg_data[MODE_W-1:0];
                default:    spot_next       = spot_reg;
            endcase
        end

        case (state_reg)
            // Take a word, apply clear, form |sample| * vol
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (clear_totals)
                    begin
                        total_next    = '0;
                        count_next    = '0;
                        avg_sum_next  = '0;
                        step_idx_next = '0;
                    end
                    neg_next   = normal_sample[SAMPLE_W-1];
                    acc_next   = ACC_W'(mul_p);
                    state_next = S_GROW;
                end
            end

            // Clamp at zero or start price times factor
            S_GROW:
            begin
                cnt_next = '0;
                if (f_clamp)
                begin
                    acc_next   = '0;
                    state_next = S_NEWP;
                end
                else
                begin
                    acc_next   = '0;
                    opa_next   = OPA_W'(f_val[F_W-3:F_FRAC]);
                    opb_next   = price_sel;
                    phase_next = PH_PRICE;
                    state_next = S_MUL;
                end
            end

            // Accumulate one chunk product per cycle
            S_MUL:
            begin
                acc_next = {acc_reg[ACC_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + ACC_W'(mul_p);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS-1))
                begin
                    case (phase_reg)
                        PH_PRICE: state_next = S_NEWP;
                        PH_AVG:   state_next = S_PCLOSE;
                        default:  state_next = S_EST;
                    endcase
                end
            end

            // New price: advance the path or close it
            S_NEWP:
            begin
                cur_price_next = newp;
                avg_sum_next   = avg_upd;
                if (!path_close)
                begin
                    step_idx_next = step_idx_reg + 1'b1;
                    state_next    = S_IDLE;
                end
                else if (mode_reg[MODE_AVG_BIT])
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    opa_next   = avg_upd;
                    opb_next   = avg_scale_reg;
                    phase_next = PH_AVG;
                    state_next = S_MUL;
                end
                else
                begin
                    pclose_next = newp;
                    state_next  = S_PAY;
                end
            end

            // Average price of the path
            S_PCLOSE:
            begin
                pclose_next = scaled31;
                state_next  = S_PAY;
            end

            // Payoff, total and count; start the estimate product
            S_PAY:
            begin
                payoff_next   = payoff_val;
                total_next    = total_upd;
                count_next    = (count_reg == {COUNT_W{1'b1}}) ? count_reg
                                                               : count_reg + 1'b1;
                avg_sum_next  = '0;
                step_idx_next = '0;
                acc_next      = '0;
                cnt_next      = '0;
                opa_next      = total_upd;
                opb_next      = mean_scale_reg;
                phase_next    = PH_EST;
                state_next    = S_MUL;
            end

            // Hold until the output register frees, then load it
            S_EST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_payoff_next = payoff_reg;
                    out_total_next  = total_reg;
                    out_count_next  = count_reg;
                    out_est_next    = scaled31;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_PRICE;
            cnt_reg        <= '0;
            acc_reg        <= '0;
            opa_reg        <= '0;
            opb_reg        <= '0;
            neg_reg        <= 1'b0;
            pclose_reg     <= '0;
            spot_reg       <= '0;
            strike_reg     <= '0;
            growth_reg     <= GROWTH_RESET;
            vol_reg        <= '0;
            steps_reg      <= STEPS_RESET;
            avg_scale_reg  <= SCALE_RESET;
            mean_scale_reg <= SCALE_RESET;
            mode_reg       <= '0;
            cur_price_reg  <= '0;
            avg_sum_reg    <= '0;
            step_idx_reg   <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            payoff_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_payoff_reg <= '0;
            out_total_reg  <= '0;
            out_count_reg  <= '0;
            out_est_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            acc_reg        <= acc_next;
            opa_reg        <= opa_next;
            opb_reg        <= opb_next;
            neg_reg        <= neg_next;
            pclose_reg     <= pclose_next;
            spot_reg       <= spot_next;
            strike_reg     <= strike_next;
            growth_reg     <= growth_next;
            vol_reg        <= vol_next;
            steps_reg      <= steps_next;
            avg_scale_reg  <= avg_scale_next;
            mean_scale_reg <= mean_scale_next;
            mode_reg       <= mode_next;
            cur_price_reg  <= cur_price_next;
            avg_sum_reg    <= avg_sum_next;
            step_idx_reg   <= step_idx_next;
            total_reg      <= total_next;
            count_reg      <= count_next;
            payoff_reg     <= payoff_next;
            out_valid_reg  <= out_valid_next;
            out_payoff_reg <= out_payoff_next;
            out_total_reg  <= out_total_next;
            out_count_reg  <= out_count_next;
            out_est_reg    <= out_est_next;
        end
    end

    // Drive the ports
    assign in_stall       = (state_reg != S_IDLE);
    assign out_valid      = out_valid_reg;
    assign path_payoff    = out_payoff_reg;
    assign payoff_total   = out_total_reg;
    assign paths_done     = out_count_reg;
    assign price_estimate = out_est_reg;

    // A closed path always leaves a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (paths_done != '0))
        else $error("result shown with zero path count");

    // The total includes the payoff just added
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (TOTAL_W'(path_payoff) <= payoff_total))
        else $error("path payoff exceeds payoff total");

    // A taken word blocks the input on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // A finished result waits while the output register is occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EST && out_valid_reg && out_stall) |=> (state_reg == S_EST))
        else $error("result overwrote a pending output word");

endmodule
